>>> rtl/core/lcsf_pkg.sv
// Shared types, codes and glyph helper for the LCD character stream formatter.
`timescale 1ns / 1ps

package lcsf_pkg;

	typedef enum logic [3:0] {
		OP_DATA   = 4'd0,
		OP_CMD    = 4'd1,
		OP_CURSOR = 4'd2,
		OP_U8     = 4'd3,
		OP_S8     = 4'd4,
		OP_U16    = 4'd5,
		OP_HEX8   = 4'd6,
		OP_HEX16  = 4'd7,
		OP_HEX32  = 4'd8
	} op_t;

	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ODD_ROW_BIT  = 8'h40;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_HEX_LO  = 8'h37;
	localparam int unsigned DEC_BASE    = 10;
	localparam int unsigned DEC_WIDTH   = 5;
	localparam int unsigned RUN_LEN     = 8;

	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] value;
		logic [2:0]  digits;
		logic [7:0]  row;
		logic [7:0]  col;
	} req_t;

	// After the hundreds split: num = hi * 100 + remainder
	typedef struct packed {
		req_t        req;
		logic        neg;
		logic [15:0] num;
		logic [9:0]  hi;
	} split_t;

	// Decimal digits, index 0 is the units digit
	typedef struct packed {
		req_t                        req;
		logic                        neg;
		logic [DEC_WIDTH-1:0][3:0]   dig;
	} digits_t;

	typedef struct packed {
		logic [RUN_LEN-1:0][7:0] chars;
		logic [3:0]              len;
		logic                    is_data;
	} run_t;

	function automatic logic [7:0] glyph(input logic [3:0] nib);
		return (nib < 4'(DEC_BASE)) ? (CHAR_ZERO + {4'h0, nib}) : (CHAR_HEX_LO + {4'h0, nib});
	endfunction

endpackage

>>> rtl/core/lcsf_if.sv
// Request and result channel interfaces of the LCD character stream formatter.
`timescale 1ns / 1ps

interface lcsf_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [31:0] value;
	logic [2:0]  digits;
	logic [7:0]  row;
	logic [7:0]  col;

	modport source(output valid, output op, output value, output digits, output row,
		output col, input ready);
	modport sink(input valid, input op, input value, input digits, input row,
		input col, output ready);
endinterface

interface lcsf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source(output valid, output out_byte, output is_data, output last, input ready);
	modport sink(input valid, input out_byte, input is_data, input last, output ready);
endinterface

>>> rtl/core/lcsf_split.sv
// Input register and hundreds split of the decimal operand.
`timescale 1ns / 1ps

module lcsf_split
	import lcsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lcsf_req_if.sink    req,
	output split_t      split,
	output logic        split_valid,
	input  logic        split_ready
);

	// floor(v / 100) is exact for every 16-bit v with this reciprocal
	localparam logic [16:0] DIV100_MUL   = 17'd83887;
	localparam int unsigned DIV100_SHIFT = 23;

	req_t        req_s1;
	logic        valid_s1;
	split_t      split_s2;
	logic        valid_s2;
	logic        free_s1;
	logic        free_s2;
	logic [7:0]  mag;
	logic [15:0] num;
	logic [32:0] prod;
	split_t      split_d;

	assign free_s2   = !valid_s2 || split_ready;
	assign free_s1   = !valid_s1 || free_s2;
	assign req.ready = free_s1;

	always_comb begin
		mag = req_s1.value[7] ? (8'd0 - req_s1.value[7:0]) : req_s1.value[7:0];
		unique case (req_s1.op)
			OP_U8:   num = {8'h00, req_s1.value[7:0]};
			OP_S8:   num = {8'h00, mag};
			default: num = req_s1.value[15:0];
		endcase
		prod = {17'h0, num} * {16'h0, DIV100_MUL};
		split_d.req = req_s1;
		split_d.neg = req_s1.value[7];
		split_d.num = num;
		split_d.hi  = prod[DIV100_SHIFT +: 10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= req.valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && free_s1) begin
			req_s1 <= '{op: req.op, value: req.value, digits: req.digits, row: req.row,
				col: req.col};
		end
		if (free_s2 && valid_s1) begin
			split_s2 <= split_d;
		end
	end

	assign split       = split_s2;
	assign split_valid = valid_s2;

endmodule

>>> rtl/core/lcsf_digits.sv
// Turns the hundreds split into five decimal digits and registers them.
`timescale 1ns / 1ps

module lcsf_digits
	import lcsf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  split_t  split,
	input  logic    split_valid,
	output logic    split_ready,
	output digits_t dgt,
	output logic    dgt_valid,
	input  logic    dgt_ready
);

	// hundreds count (0 to 6) and remainder of a value below 700
	function automatic logic [10:0] split_hund(input logic [9:0] x);
		logic [3:0] q;
		logic [6:0] r;
		q = 4'd0;
		r = x[6:0];
		for (int k = 1; k <= 6; k++) begin
			if (x >= 10'(DEC_BASE * DEC_BASE * k)) begin
				q = 4'(k);
				r = 7'(x - 10'(DEC_BASE * DEC_BASE * k));
			end
		end
		return {q, r};
	endfunction

	// tens and units of a value below 100
	function automatic logic [7:0] split_ten(input logic [6:0] x);
		logic [3:0] t;
		logic [3:0] u;
		t = 4'd0;
		u = x[3:0];
		for (int k = 1; k <= 9; k++) begin
			if (x >= 7'(DEC_BASE * k)) begin
				t = 4'(k);
				u = 4'(x - 7'(DEC_BASE * k));
			end
		end
		return {t, u};
	endfunction

	digits_t     dgt_s3;
	logic        valid_s3;
	logic        free_s3;
	logic [15:0] lo_full;
	logic [6:0]  lo;
	logic [10:0] hund;
	logic [7:0]  mid_pair;
	logic [7:0]  lo_pair;
	digits_t     dgt_d;

	assign free_s3     = !valid_s3 || dgt_ready;
	assign split_ready = free_s3;

	always_comb begin
		lo_full  = split.num - ({6'h00, split.hi} * 16'(DEC_BASE * DEC_BASE));
		lo       = lo_full[6:0];
		hund     = split_hund(split.hi);
		mid_pair = split_ten(hund[6:0]);
		lo_pair  = split_ten(lo);
		dgt_d.req    = split.req;
		dgt_d.neg    = split.neg;
		dgt_d.dig[4] = hund[10:7];
		dgt_d.dig[3] = mid_pair[7:4];
		dgt_d.dig[2] = mid_pair[3:0];
		dgt_d.dig[1] = lo_pair[7:4];
		dgt_d.dig[0] = lo_pair[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free_s3) begin
			valid_s3 <= split_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && split_valid) begin
			dgt_s3 <= dgt_d;
		end
	end

	assign dgt       = dgt_s3;
	assign dgt_valid = valid_s3;

endmodule

>>> rtl/core/lcsf_fmt.sv
// Builds the byte run of one request from its digits, operand and cursor position.
`timescale 1ns / 1ps

module lcsf_fmt
	import lcsf_pkg::*;
#(
	parameter int unsigned COLUMNS   = 16,
	parameter int unsigned ROW_COUNT = 4
) (
	input  digits_t dgt,
	input  logic    dgt_valid,
	output logic    dgt_ready,
	output run_t    run,
	output logic    run_valid,
	input  logic    run_ready
);

	always_comb begin
		logic [4:0][7:0] c;
		logic [4:0][7:0] w;
		logic            z;
		logic [2:0]      width;
		logic [2:0]      shown;
		logic [2:0]      off;
		logic [3:0]      pos;
		logic [7:0]      addr;
		logic            cur_ok;

		// c[0] is the leftmost character; leading zeros blank, the units digit never does
		z = 1'b1;
		for (int i = 0; i < 4; i++) begin
			z    = z & (dgt.dig[4 - i] == 4'd0);
			c[i] = z ? CHAR_SPACE : glyph(dgt.dig[4 - i]);
		end
		c[4] = glyph(dgt.dig[0]);

		width = (dgt.req.op == OP_U16) ? 3'd5 : 3'd3;
		shown = (dgt.req.digits > width) ? width : dgt.req.digits;
		off   = 3'd5 - shown;
		for (int k = 0; k < 5; k++) begin
			pos  = {1'b0, off} + 4'(k);
			w[k] = (3'(k) < shown) ? c[pos[2:0]] : CHAR_SPACE;
		end

		cur_ok = (dgt.req.col < 8'(COLUMNS)) && (dgt.req.row < 8'(ROW_COUNT));
		addr   = dgt.req.col | (dgt.req.row[1] ? 8'(COLUMNS) : 8'h00) | CMD_SET_ADDR
			| (dgt.req.row[0] ? ODD_ROW_BIT : 8'h00);

		run         = '0;
		run.is_data = 1'b1;
		unique case (dgt.req.op)
			OP_DATA: begin
				run.chars[0] = dgt.req.value[7:0];
				run.len      = 4'd1;
			end
			OP_CMD: begin
				run.chars[0] = dgt.req.value[7:0];
				run.len      = 4'd1;
				run.is_data  = 1'b0;
			end
			OP_CURSOR: begin
				run.chars[0] = addr;
				run.len      = cur_ok ? 4'd1 : 4'd0;
				run.is_data  = 1'b0;
			end
			OP_U8, OP_U16: begin
				for (int k = 0; k < 5; k++) begin
					run.chars[k] = w[k];
				end
				run.len = {1'b0, shown};
			end
			OP_S8: begin
				run.chars[0] = dgt.neg ? CHAR_MINUS : CHAR_SPACE;
				for (int k = 0; k < 5; k++) begin
					run.chars[k + 1] = w[k];
				end
				run.len = {1'b0, shown} + 4'd1;
			end
			OP_HEX8: begin
				for (int k = 0; k < 2; k++) begin
					run.chars[k] = glyph(dgt.req.value[4 * (1 - k) +: 4]);
				end
				run.len = 4'd2;
			end
			OP_HEX16: begin
				for (int k = 0; k < 4; k++) begin
					run.chars[k] = glyph(dgt.req.value[4 * (3 - k) +: 4]);
				end
				run.len = 4'd4;
			end
			OP_HEX32: begin
				for (int k = 0; k < 8; k++) begin
					run.chars[k] = glyph(dgt.req.value[4 * (7 - k) +: 4]);
				end
				run.len = 4'd8;
			end
			default: begin
				run.len = 4'd0;
			end
		endcase
	end

	// Requests that produce no bytes are simply dropped here.
	assign run_valid = dgt_valid && (run.len != 4'd0);
	assign dgt_ready = (run.len == 4'd0) || run_ready;

endmodule

>>> rtl/core/lcsf_ser.sv
// Holds one byte run and sends it out one beat per cycle while rsp.ready is high.
`timescale 1ns / 1ps

module lcsf_ser
	import lcsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  run_t        run,
	input  logic        run_valid,
	output logic        run_ready,
	lcsf_byte_if.source rsp
);

	run_t       run_q;
	logic [2:0] idx_q;
	logic       full_q;
	logic       is_last;
	logic       out_fire;
	logic       in_fire;

	assign is_last  = ({1'b0, idx_q} + 4'd1) == run_q.len;
	assign out_fire = full_q && rsp.ready;
	// The next run loads while the final beat of the current one is taken.
	assign run_ready = !full_q || (rsp.ready && is_last);
	assign in_fire   = run_valid && run_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (in_fire) begin
			full_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (out_fire) begin
			if (is_last) begin
				full_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			run_q <= run;
		end
	end

	assign rsp.valid    = full_q;
	assign rsp.out_byte = run_q.chars[idx_q];
	assign rsp.is_data  = run_q.is_data;
	assign rsp.last     = is_last;

endmodule

>>> rtl/core/lcd_character_stream_formatter_unit.sv
// Top level of the LCD character stream formatter: request in, byte beats out.
// A run's first byte is offered once its request passes req_s1, split_s2, dgt_s3 and run_q.
// Throughput: the serializer sends one byte per cycle while rsp.ready is high; a run holds
// up to 8 bytes, and the next run loads as the last byte of the current one is taken.
// Reset: arst_n clears every pipeline valid and the serializer at once; no output follows.
`timescale 1ns / 1ps

module lcd_character_stream_formatter_unit
	import lcsf_pkg::*;
#(
	parameter int unsigned COLUMNS   = 16,
	parameter int unsigned ROW_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	lcsf_req_if.sink    req,
	lcsf_byte_if.source rsp
);

	split_t  split;
	logic    split_valid;
	logic    split_ready;
	digits_t dgt;
	logic    dgt_valid;
	logic    dgt_ready;
	run_t    run;
	logic    run_valid;
	logic    run_ready;

	lcsf_split u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.split       (split),
		.split_valid (split_valid),
		.split_ready (split_ready)
	);

	lcsf_digits u_digits (
		.clk         (clk),
		.arst_n      (arst_n),
		.split       (split),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.dgt         (dgt),
		.dgt_valid   (dgt_valid),
		.dgt_ready   (dgt_ready)
	);

	lcsf_fmt #(
		.COLUMNS   (COLUMNS),
		.ROW_COUNT (ROW_COUNT)
	) u_fmt (
		.dgt       (dgt),
		.dgt_valid (dgt_valid),
		.dgt_ready (dgt_ready),
		.run       (run),
		.run_valid (run_valid),
		.run_ready (run_ready)
	);

	lcsf_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.rsp       (rsp)
	);

endmodule
